>>> src/crt_pkg.sv
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types and constants for the committed range table.
// ----------------------------------------------------------------------------
package crt_pkg;

  // Default number of table entries.
  localparam int TableEntriesDef = 16;

  // Operation codes carried on the func field.
  localparam logic [1:0] FUNC_COMMIT = 2'd0;
  localparam logic [1:0] FUNC_QUERY  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_PAGE_SIZE_LOG2 = 1'b0;

  // Reset value of the page size register (4 KiB pages).
  localparam logic [4:0] PageLog2Reset = 5'd12;

  // Exclusive top of the 32-bit address window.
  localparam logic [32:0] WindowTop = 33'h1_0000_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // Register an accepted transaction.
    logic execute;  // Update the table and load the output register.
  } crt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // The output register can take a result this cycle.
  } crt_stat_t;

endpackage

>>> src/committed_range_table.sv
// ----------------------------------------------------------------------------
// committed_range_table
// Table of committed address ranges with commit, query and clear operations.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+------------------------------
//   input    | in_valid/in_stall  | func, addr, size
//   output   | out_valid/out_stall| is_mapped, status
//   config   | APB write/read     | page_size_log2 at address 0
//
// Each transaction first has its range aligned and captured, and is then compared
// against all entries in parallel while the table is updated.
// A transaction waits in the update cycle while the output register holds a
// result that is stalled; a new transaction is taken while a result waits.
// Reset empties the table and sets the page size to 4 KiB; entry contents are
// not cleared, as only entries below the fill count are ever read.
//
module committed_range_table import crt_pkg::*; #(
  parameter int TableEntries = TableEntriesDef
) (
  input  logic        clk,
  input  logic        rst,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] addr,
  input  logic [31:0] size,
  // Output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_mapped,
  output logic [1:0]  status,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  crt_cmd_t   cmd;
  crt_stat_t  stat;
  logic [4:0] page_size_log2;

  // Configuration register, word-decoded.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size_log2 <= PageLog2Reset;
    end else if (psel && penable && pwrite && (paddr[2] == REG_PAGE_SIZE_LOG2)) begin
      page_size_log2 <= pwdata[4:0];
    end
  end

  assign prdata = (paddr[2] == REG_PAGE_SIZE_LOG2) ? {27'd0, page_size_log2} : 32'd0;

  // Controller.
  crt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath.
  crt_datapath #(
    .TableEntries (TableEntries)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .page_size_log2 (page_size_log2),
    .func           (func),
    .addr           (addr),
    .size           (size),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .is_mapped      (is_mapped),
    .status         (status)
  );

endmodule

>>> src/crt_ctrl.sv
// ----------------------------------------------------------------------------
// crt_ctrl
// Controller for the committed range table: sequences capture and update.
// ----------------------------------------------------------------------------
module crt_ctrl import crt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  crt_stat_t stat,
  output crt_cmd_t  cmd
);

  typedef enum logic [1:0] {
    IDLE   = 2'b01,
    UPDATE = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // The input side is open only while no transaction is in the datapath.
  assign in_stall = (state != IDLE);

  // Next state and commands.
  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = UPDATE;
        end
      end
      UPDATE: begin
        if (stat.out_free) begin
          cmd.execute = 1'b1;
          state_next  = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/crt_datapath.sv
// ----------------------------------------------------------------------------
// crt_datapath
// Range alignment, the entry table with per-entry compare, and the result
// register of the committed range table.
// ----------------------------------------------------------------------------
module crt_datapath import crt_pkg::*; #(
  parameter int TableEntries = TableEntriesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  crt_cmd_t    cmd,
  output crt_stat_t   stat,
  input  logic [4:0]  page_size_log2,
  input  logic [1:0]  func,
  input  logic [31:0] addr,
  input  logic [31:0] size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_mapped,
  output logic [1:0]  status
);

  localparam int CountW = $clog2(TableEntries + 1);

  // Aligned commit range and query bounds, computed on the incoming transaction.
  logic [32:0] mask_c;
  logic [31:0] lo_c;
  logic [33:0] sum_c;
  logic [33:0] hi_raw_c;
  logic [32:0] hi_c;
  logic        empty_c;
  logic [32:0] last_c;

  always_comb begin
    mask_c   = (33'd1 << page_size_log2) - 33'd1;
    lo_c     = addr & ~mask_c[31:0];
    sum_c    = {2'b00, addr} + {2'b00, size} + {1'b0, mask_c};
    hi_raw_c = sum_c & ~{1'b0, mask_c};
    hi_c     = (hi_raw_c > {1'b0, WindowTop}) ? WindowTop : hi_raw_c[32:0];
    empty_c  = (size == 32'd0) || (hi_c <= {1'b0, lo_c});
    last_c   = {1'b0, addr} + {1'b0, size} - 33'd1;
  end

  // Operand registers for the update cycle.
  logic [1:0]  op_func;
  logic [31:0] op_lo;
  logic [32:0] op_hi;
  logic        op_empty;
  logic [31:0] q_first;
  logic [31:0] q_last;
  logic        q_zero;
  logic        q_over;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_func  <= func;
      op_lo    <= lo_c;
      op_hi    <= hi_c;
      op_empty <= empty_c;
      q_first  <= addr;
      q_last   <= last_c[31:0];
      q_zero   <= (size == 32'd0);
      q_over   <= last_c[32];
    end
  end

  // Entry table; entries at or above the fill count are never consulted.
  logic [31:0]       range_start [TableEntries];
  logic [32:0]       range_end   [TableEntries];
  logic [CountW-1:0] range_count;

  // Per-entry compares, all entries in parallel.
  logic [TableEntries-1:0] hit;
  logic [TableEntries-1:0] first_hit;
  logic [TableEntries-1:0] fhit;
  logic [TableEntries-1:0] lhit;
  logic [TableEntries-1:0] slot;

  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      logic used;
      used    = (CountW'(i) < range_count);
      hit[i]  = used && ({1'b0, op_lo} <= range_end[i]) &&
                (op_hi >= {1'b0, range_start[i]});
      fhit[i] = used && (q_first >= range_start[i]) &&
                ({1'b0, q_first} < range_end[i]);
      lhit[i] = used && (q_last >= range_start[i]) &&
                ({1'b0, q_last} < range_end[i]);
      slot[i] = (range_count == CountW'(i));
    end
    first_hit = hit & (~hit + {{(TableEntries-1){1'b0}}, 1'b1});
  end

  logic any_hit;
  logic full;
  logic do_commit;
  logic do_append;

  assign any_hit   = |hit;
  assign full      = (range_count == CountW'(TableEntries));
  assign do_commit = cmd.execute && (op_func == FUNC_COMMIT) && !op_empty;
  assign do_append = do_commit && !any_hit && !full;

  // Widen the first touching entry, or write the range into the next free one.
  always_ff @(posedge clk) begin
    for (int i = 0; i < TableEntries; i++) begin
      if (do_commit && first_hit[i]) begin
        if ({1'b0, op_lo} < {1'b0, range_start[i]}) begin
          range_start[i] <= op_lo;
        end
        if (op_hi > range_end[i]) begin
          range_end[i] <= op_hi;
        end
      end else if (do_append && slot[i]) begin
        range_start[i] <= op_lo;
        range_end[i]   <= op_hi;
      end
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_count <= '0;
    end else if (do_append) begin
      range_count <= range_count + CountW'(1);
    end else if (cmd.execute && (op_func == FUNC_CLEAR)) begin
      range_count <= '0;
    end
  end

  // Result of the transaction in the update cycle.
  logic       mapped_c;
  logic [1:0] status_c;

  always_comb begin
    mapped_c = (op_func == FUNC_QUERY) && (q_zero || (!q_over && (|fhit) && (|lhit)));
    status_c = ST_DONE;
    if (op_func == FUNC_COMMIT) begin
      if (op_empty) begin
        status_c = ST_EMPTY;
      end else if (!any_hit && full) begin
        status_c = ST_FULL;
      end
    end
  end

  // Output register.
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      is_mapped <= mapped_c;
      status    <= status_c;
    end
  end

endmodule

>>> src/crt_checker.sv
// ----------------------------------------------------------------------------
// crt_checker
// Port-level checks for the committed range table, bound to the top level.
// ----------------------------------------------------------------------------
module crt_checker import crt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  func,
  input logic [31:0] addr,
  input logic [31:0] size,
  input logic        out_valid,
  input logic        out_stall,
  input logic        is_mapped,
  input logic [1:0]  status
);

  // A stalled input transaction stays offered with the same payload.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(func) && $stable(addr) && $stable(size))
    else $error("input transaction changed while stalled");

  // A stalled result stays offered with the same payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(is_mapped) && $stable(status))
    else $error("result changed while stalled");

  // An accepted transaction closes the input side for its update cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted in the update cycle");

  // Results with a status other than done, which only commits give, never report a mapped range.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DONE) |-> !is_mapped)
    else $error("mapped flag set on a commit result");

  // Every result follows an accepted transaction.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without an accepted transaction");

endmodule

bind committed_range_table crt_checker u_crt_checker (.*);
